### sv/msq_pkg.sv
`default_nettype none
package msq_pkg;

	localparam int STORE_DEPTH_DEF = 256;
	localparam int WORD_W          = 32;
	localparam int PC_W            = 8;

	// command codes
	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_FETCH   = 2'd1;
	localparam logic [1:0] CMD_ADVANCE = 2'd2;

	// branch conditions
	localparam logic [1:0] COND_NEVER  = 2'd0;
	localparam logic [1:0] COND_NEG    = 2'd1;
	localparam logic [1:0] COND_ZERO   = 2'd2;
	localparam logic [1:0] COND_JUMP   = 2'd3;

	localparam logic [PC_W-1:0] JUMP_DISPATCH = 8'hFF;
	localparam logic [PC_W-1:0] DISPATCH_BASE = 8'h14;
	localparam logic [PC_W-1:0] DISPATCH_STEP = 8'h04;

	localparam logic [3:0] OP_STEP_0 = 4'h4;
	localparam logic [3:0] OP_STEP_1 = 4'h9;
	localparam logic [3:0] OP_STEP_2 = 4'hA;
	localparam logic [3:0] OP_STEP_3 = 4'hB;
	localparam logic [3:0] OP_STEP_4 = 4'hC;
	localparam logic [3:0] OP_STEP_5 = 4'hF;

	typedef struct packed {
		logic store_we;
		logic store_re;
		logic ir_we;
		logic adv;
		logic err_we;
		logic err_val;
	} cmd_t;

	typedef struct packed {
		logic load_ok;
		logic fetch_ok;
	} sts_t;

	// dispatch entry: base + 4*op, one extra step per threshold reached
	function automatic logic [PC_W-1:0] dispatch_target(input logic [3:0] op);
		logic [PC_W-1:0] t;
		t = DISPATCH_BASE + {2'b00, op, 2'b00};
		if (op >= OP_STEP_0) t = t + DISPATCH_STEP;
		if (op >= OP_STEP_1) t = t + DISPATCH_STEP;
		if (op >= OP_STEP_2) t = t + DISPATCH_STEP;
		if (op >= OP_STEP_3) t = t + DISPATCH_STEP;
		if (op >= OP_STEP_4) t = t + DISPATCH_STEP;
		if (op >= OP_STEP_5) t = t + DISPATCH_STEP;
		return t;
	endfunction

endpackage
`default_nettype wire

### sv/msq_ctrl.sv
`default_nettype none
module msq_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	output logic             out_valid,
	input  wire logic        out_stall,
	input  wire msq_pkg::sts_t sts,
	output msq_pkg::cmd_t    cmd
);
	import msq_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_FETCH = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;
	logic   is_load, is_fetch;

	// result slot is out_valid_q, so only accept once the last word is gone or is taken now, and never in ST_FETCH
	assign in_stall  = (state_q == ST_FETCH) || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	assign is_load  = (command == CMD_LOAD);
	assign is_fetch = (command == CMD_FETCH);

	always_comb begin
		cmd          = '0;
		cmd.store_we = accept && is_load && sts.load_ok;
		cmd.store_re = accept && is_fetch && sts.fetch_ok;
		cmd.adv      = accept && (command == CMD_ADVANCE);
		cmd.ir_we    = (state_q == ST_FETCH);
		cmd.err_we   = accept;
		cmd.err_val  = (is_load && !sts.load_ok) || (is_fetch && !sts.fetch_ok);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.store_re) state_d = ST_FETCH;
			end
			ST_FETCH: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((accept && !cmd.store_re) || (state_q == ST_FETCH))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	a_fetch_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |=> (state_q == ST_IDLE))
		else $error("fetch state held longer than one cycle");

	a_slot_free_in_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |-> !out_valid_q)
		else $error("result slot busy while fetch completes");

	a_fetch_then_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_re |=> (state_q == ST_FETCH) ##1 out_valid_q)
		else $error("fetch did not produce a result word");

endmodule
`default_nettype wire

### sv/msq_dp.sv
`default_nettype none
module msq_dp #(
	parameter int STORE_DEPTH = msq_pkg::STORE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire msq_pkg::cmd_t cmd,
	output msq_pkg::sts_t    sts,
	input  wire logic [7:0]  load_address,
	input  wire logic [31:0] load_word,
	input  wire logic        neg_flag,
	input  wire logic        zero_flag,
	input  wire logic [3:0]  opcode,
	output logic [7:0]       counter_q,
	output logic [31:0]      ir_q,
	output logic             err_q
);
	import msq_pkg::*;

	localparam int         AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam logic [8:0] DEPTH = 9'(STORE_DEPTH);

	logic [WORD_W-1:0]      mem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] wr_vld_q;
	logic [WORD_W-1:0]      rd_data_q;
	logic                   rd_vld_q;
	logic [AW-1:0]          ld_idx, rd_idx;

	logic [1:0]      cond;
	logic [7:0]      target;
	logic            take;
	logic [PC_W-1:0] counter_d;

	assign sts.load_ok  = {1'b0, load_address} < DEPTH;
	assign sts.fetch_ok = {1'b0, counter_q} < DEPTH;

	assign ld_idx = load_address[AW-1:0];
	assign rd_idx = counter_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.store_we) mem[ld_idx] <= load_word;
		if (cmd.store_re) rd_data_q <= mem[rd_idx];
	end

	// an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.store_we) wr_vld_q[ld_idx] <= 1'b1;
			if (cmd.store_re) rd_vld_q <= wr_vld_q[rd_idx];
		end
	end

	assign cond   = ir_q[2:1];
	assign target = ir_q[31:24];

	always_comb begin
		case (cond)
			COND_NEVER:  take = 1'b0;
			COND_NEG:    take = neg_flag;
			COND_ZERO:   take = zero_flag;
			COND_JUMP:   take = 1'b1;
			default:     take = 1'b0;
		endcase
		if (!take)
			counter_d = counter_q + 8'd1;
		else if ((cond == COND_JUMP) && (target == JUMP_DISPATCH))
			counter_d = dispatch_target(opcode);
		else
			counter_d = target;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			ir_q      <= '0;
			err_q     <= 1'b0;
		end else begin
			if (cmd.adv)    counter_q <= counter_d;
			if (cmd.ir_we)  ir_q      <= rd_vld_q ? rd_data_q : '0;
			if (cmd.err_we) err_q     <= cmd.err_val;
		end
	end

endmodule
`default_nettype wire

### sv/microprogram_sequencer.sv
`default_nettype none
// Microsequencer with a control store of STORE_DEPTH 32-bit words, a micro
// program counter and a microinstruction register. Commands: load a store
// word, fetch the word at the counter, advance the counter (increment, branch
// on N or Z, jump, or opcode dispatch when the jump target is 0xFF). Load and
// advance act as they are accepted; a fetch first registers the store read,
// then writes the register in the fetch state, stalling input. The outputs
// show the counter and register after each word; a new input word is taken
// once the previous result word has been taken or in the same cycle. Store
// entries carry valid bits cleared by reset, so no clearing pass is needed.
module microprogram_sequencer #(
	parameter int STORE_DEPTH = msq_pkg::STORE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [7:0]  load_address,
	input  wire logic [31:0] load_word,
	input  wire logic        neg_flag,
	input  wire logic        zero_flag,
	input  wire logic [3:0]  opcode,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       counter_value,
	output logic [7:0]       next_address,
	output logic [3:0]       a_select,
	output logic [3:0]       b_select,
	output logic [3:0]       c_select,
	output logic [4:0]       strobes,
	output logic [1:0]       shift_code,
	output logic [1:0]       alu_code,
	output logic [1:0]       cond_code,
	output logic             amux_select,
	output logic             error
);
	import msq_pkg::*;

	cmd_t        cmd;
	sts_t        sts;
	logic [31:0] ir;

	msq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	msq_dp #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.load_address (load_address),
		.load_word    (load_word),
		.neg_flag     (neg_flag),
		.zero_flag    (zero_flag),
		.opcode       (opcode),
		.counter_q    (counter_value),
		.ir_q         (ir),
		.err_q        (error)
	);

	assign next_address = ir[31:24];
	assign a_select     = ir[23:20];
	assign b_select     = ir[19:16];
	assign c_select     = ir[15:12];
	assign strobes      = ir[11:7];
	assign shift_code   = ir[6:5];
	assign alu_code     = ir[4:3];
	assign cond_code    = ir[2:1];
	assign amux_select  = ir[0];

endmodule
`default_nettype wire
